@@ rtl/ttst_pkg.sv @@
// Shared types and constants of the tick task scheduler table.
package ttst_pkg;

	// action codes of a command beat
	localparam logic [1:0] ACT_TICK     = 2'd0;
	localparam logic [1:0] ACT_ADD      = 2'd1;
	localparam logic [1:0] ACT_DISPATCH = 2'd2;
	localparam logic [1:0] ACT_CLEAR    = 2'd3;

	// status codes of a result beat
	localparam logic [2:0] STS_DONE  = 3'd0;
	localparam logic [2:0] STS_ADDED = 3'd1;
	localparam logic [2:0] STS_FULL  = 3'd2;
	localparam logic [2:0] STS_RUN   = 3'd3;
	localparam logic [2:0] STS_NONE  = 3'd4;
	localparam logic [2:0] STS_NULL  = 3'd5;

	// most run results one dispatch may give
	localparam int RESULT_CAP = 8;
	localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

	typedef struct packed {
		logic [7:0]  handle;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  pending;
	} slot_entry_t;

	// control group from the sequencer to the slot memory
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic free_en;
		logic clear_all;
	} mem_ctrl_t;

endpackage

@@ rtl/ttst_if.sv @@
// Command and result channel interfaces of the tick task scheduler table.
interface ttst_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  task_handle;
	logic [15:0] period;
	logic [15:0] delay;

	modport source (output valid, action, task_handle, period, delay, input ready);
	modport sink   (input valid, action, task_handle, period, delay, output ready);
endinterface

interface ttst_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [2:0] slot;
	logic [7:0] run_handle;
	logic       last;

	modport source (output valid, status, slot, run_handle, last, input ready);
	modport sink   (input valid, status, slot, run_handle, last, output ready);
endinterface

@@ rtl/ttst_slot_mem.sv @@
// Slot memory with per-slot occupied bits; a free slot reads as all zero.
module ttst_slot_mem
	import ttst_pkg::*;
#(
	parameter int DEPTH  = 8,
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_ctrl_t         ctrl,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ADDR_W-1:0] free_addr,
	input  slot_entry_t       wr_data,
	output slot_entry_t       rd_data,
	output logic              rd_occ,
	output logic [DEPTH-1:0]  occ
);

	slot_entry_t       mem [0:DEPTH-1];
	slot_entry_t       data_s1;
	logic              occ_s1;
	logic [DEPTH-1:0]  occ_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			occ_s1 <= 1'b0;
		end else begin
			if (ctrl.clear_all) begin
				occ_q <= '0;
			end else begin
				if (ctrl.wr_en) begin
					occ_q[wr_addr] <= 1'b1;
				end
				if (ctrl.free_en) begin
					occ_q[free_addr] <= 1'b0;
				end
			end
			if (ctrl.rd_en) begin
				occ_s1 <= occ_q[rd_addr];
			end
		end
	end

	assign rd_occ  = occ_s1;
	assign rd_data = occ_s1 ? data_s1 : '0;
	assign occ     = occ_q;

endmodule

@@ rtl/tick_task_scheduler_table.sv @@
// Top level of the tick task scheduler table: command sequencer and result register.
//
// Usage: command beats arrive on cmd (action, task_handle, period, delay) and
// result beats leave on rsp (status, slot, run_handle, last). Every command
// gives one or more result beats; last marks the final beat of a command.
// One command is worked at a time; cmd.ready is high only while idle.
// Add and clear go from accept to the final state. Tick and dispatch walk
// the slot memory one slot per cycle unless stalled, reading a slot while
// the previous one is written back. Dispatch holds each found run result
// until the next find or the end of the sweep, so that the final one can
// carry last; a later find waits while rsp is stalled and the register
// full. The result register parts the two sides: a new command can be
// taken while the last beat of the previous one still waits on rsp.ready.
// Reset clears the occupied bit of every slot at once, so all slots read
// free with zero fields; no clearing pass is needed. Clear does the same
// at once. A stalled rsp holds its beat and blocks only further results.
module tick_task_scheduler_table
	import ttst_pkg::*;
#(
	parameter int TASK_SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ttst_cmd_if.sink   cmd,
	ttst_rsp_if.source rsp
);

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;

	// slot index masked to the 3-bit result field
	function automatic logic [2:0] slot3(input logic [IDX_W-1:0] i);
		logic [IDX_W+2:0] e;
		e = {3'b000, i};
		return e[2:0];
	endfunction

	logic [1:0]           state_q;
	logic [1:0]           act_q;
	logic [IDX_W-1:0]     idx_q;
	logic [RES_CNT_W-1:0] cnt_q;

	// held result: the final beat of the command, or the latest run found
	logic                 held_valid_q;
	logic [2:0]           held_status_q;
	logic [2:0]           held_slot_q;
	logic [7:0]           held_handle_q;

	// result register
	logic                 out_valid_q;
	logic [2:0]           out_status_q;
	logic [2:0]           out_slot_q;
	logic [7:0]           out_handle_q;
	logic                 out_last_q;

	mem_ctrl_t            ctrl;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     wr_addr;
	logic [IDX_W-1:0]     free_addr;
	slot_entry_t          wr_data;
	slot_entry_t          rd_data;
	logic                 rd_occ;
	logic [TASK_SLOTS-1:0] occ;

	logic                 accept;
	logic                 out_free;
	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic                 is_disp;
	logic                 ready_s;
	logic                 stall;
	logic                 adv;
	logic                 done;
	logic [RES_CNT_W-1:0] cnt_next;
	logic                 push_sweep;
	logic                 push_fin;

	ttst_slot_mem #(
		.DEPTH  (TASK_SLOTS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.free_addr (free_addr),
		.wr_data   (wr_data),
		.rd_data   (rd_data),
		.rd_occ    (rd_occ),
		.occ       (occ)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!occ[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// sweep step on the slot most recently read
	assign is_disp    = (act_q == ACT_DISPATCH);
	assign ready_s    = is_disp && (rd_data.pending != 8'd0);
	assign stall      = (state_q == ST_SWEEP) && ready_s && held_valid_q && !out_free;
	assign adv        = (state_q == ST_SWEEP) && !stall;
	assign cnt_next   = cnt_q + RES_CNT_W'(1);
	assign done       = (idx_q == LAST_IDX) ||
	                    (ready_s && (cnt_next == RES_CNT_W'(RESULT_CAP)));
	assign push_sweep = adv && ready_s && held_valid_q;
	assign push_fin   = (state_q == ST_FIN) && out_free;

	// memory commands
	always_comb begin
		ctrl      = '0;
		rd_addr   = '0;
		wr_addr   = idx_q;
		free_addr = idx_q;
		wr_data   = rd_data;
		if (accept) begin
			case (cmd.action)
				ACT_TICK, ACT_DISPATCH: begin
					ctrl.rd_en = 1'b1;
				end
				ACT_ADD: begin
					if (cmd.task_handle != 8'd0 && free_found) begin
						ctrl.wr_en     = 1'b1;
						wr_addr        = free_idx;
						wr_data.handle = cmd.task_handle;
						wr_data.delay  = cmd.delay;
						wr_data.period = cmd.period;
						wr_data.pending = 8'd0;
					end
				end
				default: begin
					ctrl.clear_all = 1'b1;
				end
			endcase
		end else if (adv) begin
			ctrl.rd_en = !done;
			rd_addr    = idx_q + IDX_W'(1);
			if (is_disp) begin
				if (ready_s) begin
					if (rd_data.period == 16'd0) begin
						ctrl.free_en = 1'b1;
					end else begin
						ctrl.wr_en      = 1'b1;
						wr_data.pending = rd_data.pending - 8'd1;
					end
				end
			end else if (rd_occ) begin
				// tick: due slot counts a run and reloads, others count down
				ctrl.wr_en = 1'b1;
				if (rd_data.delay == 16'd0) begin
					if (rd_data.pending != 8'hFF) begin
						wr_data.pending = rd_data.pending + 8'd1;
					end
					wr_data.delay = rd_data.period;
				end else begin
					wr_data.delay = rd_data.delay - 16'd1;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= ACT_TICK;
			idx_q        <= '0;
			cnt_q        <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q        <= cmd.action;
						idx_q        <= '0;
						cnt_q        <= '0;
						held_valid_q <= (cmd.action != ACT_DISPATCH);
						if (cmd.action == ACT_TICK || cmd.action == ACT_DISPATCH) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SWEEP: begin
					if (adv) begin
						if (ready_s) begin
							held_valid_q <= 1'b1;
							cnt_q        <= cnt_next;
						end
						if (done) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_FIN: begin
					if (push_fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (push_sweep || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// held result and result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			held_slot_q   <= 3'd0;
			held_handle_q <= 8'd0;
			case (cmd.action)
				ACT_ADD: begin
					if (cmd.task_handle == 8'd0) begin
						held_status_q <= STS_NULL;
					end else if (!free_found) begin
						held_status_q <= STS_FULL;
					end else begin
						held_status_q <= STS_ADDED;
						held_slot_q   <= slot3(free_idx);
					end
				end
				default: begin
					held_status_q <= STS_DONE;
				end
			endcase
		end else if (adv && ready_s) begin
			held_status_q <= STS_RUN;
			held_slot_q   <= slot3(idx_q);
			held_handle_q <= rd_data.handle;
		end

		if (push_sweep) begin
			out_status_q <= held_status_q;
			out_slot_q   <= held_slot_q;
			out_handle_q <= held_handle_q;
			out_last_q   <= 1'b0;
		end else if (push_fin) begin
			out_last_q <= 1'b1;
			if (held_valid_q) begin
				out_status_q <= held_status_q;
				out_slot_q   <= held_slot_q;
				out_handle_q <= held_handle_q;
			end else begin
				// dispatch found nothing pending
				out_status_q <= STS_NONE;
				out_slot_q   <= 3'd0;
				out_handle_q <= 8'd0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot       = out_slot_q;
	assign rsp.run_handle = out_handle_q;
	assign rsp.last       = out_last_q;

endmodule

@@ rtl/ttst_checker.sv @@
// Port-level checks of the tick task scheduler table, bound to the top level.
module ttst_checker
	import ttst_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_status,
	input logic [7:0] rsp_run_handle,
	input logic       rsp_last
);

	// a stalled result beat stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// one command at a time: busy right after a command beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous still in work");

	// a run result always names a real task, other results never do
	a_run_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_status == STS_RUN) == (rsp_run_handle != 8'd0)))
		else $error("run handle does not match status");

	// only run results can be followed by more beats of the same command
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STS_RUN) |-> rsp_last)
		else $error("non-run result without last");

endmodule

bind tick_task_scheduler_table ttst_checker u_ttst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_run_handle (rsp.run_handle),
	.rsp_last       (rsp.last)
);
